@@ design/bqf_pkg.sv @@
// Shared types and constants for the biquad IIR filter.
// Holds the sequencer control word, the operand select codes and the register indexes.
// No dependencies.
package bqf_pkg;

   // Configuration register map.
   localparam int NUM_COEFS       = 5;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_B0 = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_B1 = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_B2 = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_A1 = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_A2 = 3'd4;

   // Coefficient operand of the shared multiplier.
   typedef enum logic [2:0] {
      COEF_B0,
      COEF_B1,
      COEF_B2,
      COEF_A1,
      COEF_A2
   } coef_sel_type;

   // Sample operand of the shared multiplier: new input or fed-back output.
   typedef enum logic {
      SAMP_X,
      SAMP_Y
   } samp_sel_type;

   // Accumulator operation for one step.
   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_ADD_D1,
      ACC_ADD_D2,
      ACC_SUB,
      ACC_LOAD
   } acc_op_type;

   // Control word from the sequencer to the multiply-accumulate unit.
   typedef struct packed {
      logic         load_x;
      samp_sel_type samp_sel;
      coef_sel_type coef_sel;
      acc_op_type   acc_op;
      logic         load_y;
      logic         load_d1;
      logic         load_d2;
      logic         load_out;
   } ctrl_type;

endpackage

@@ design/bqf_mac.sv @@
// Shared multiply-accumulate unit of the biquad filter, with the delay terms.
// One registered multiplier, one accumulator, output rounding and saturation.
// Depends on bqf_pkg.
module bqf_mac #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int COEF_WIDTH   = 32,
   parameter int STATE_WIDTH  = 48
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  bqf_pkg::ctrl_type                              ctrl,
   input  logic [SAMPLE_WIDTH-1:0]                        sample_in,
   input  logic [bqf_pkg::NUM_COEFS-1:0][COEF_WIDTH-1:0]  coefs,
   output logic [SAMPLE_WIDTH-1:0]                        sample_out,
   output logic                                           saturated
);

   localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int WIDE_W = (PROD_W > STATE_WIDTH) ? PROD_W : STATE_WIDTH;
   localparam int ACC_W  = WIDE_W + 2;
   localparam int FRAC   = COEF_WIDTH - 4;
   localparam int RND_W  = ACC_W + 1;
   localparam int SHR_W  = RND_W - FRAC;

   localparam logic [RND_W-1:0] ROUND_BIAS = RND_W'(1) << (FRAC - 1);
   localparam logic [SHR_W-1:0] Y_MAX =
      {{(SHR_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
   localparam logic [SHR_W-1:0] Y_MIN = ~Y_MAX;
   localparam logic [ACC_W-1:0] D_MAX =
      {{(ACC_W - STATE_WIDTH + 1){1'b0}}, {(STATE_WIDTH - 1){1'b1}}};
   localparam logic [ACC_W-1:0] D_MIN = ~D_MAX;

   logic signed [SAMPLE_WIDTH-1:0] x_ff, x_in;
   logic signed [SAMPLE_WIDTH-1:0] y_ff, y_in;
   logic signed [PROD_W-1:0]       prod_ff, prod_in;
   logic signed [ACC_W-1:0]        acc_ff, acc_in;
   logic signed [STATE_WIDTH-1:0]  d1_ff, d1_in;
   logic signed [STATE_WIDTH-1:0]  d2_ff, d2_in;
   logic                           sat_ff, sat_in;

   logic signed [SAMPLE_WIDTH-1:0] samp_op;
   logic signed [COEF_WIDTH-1:0]   coef_op;
   logic signed [ACC_W-1:0]        prod_ext;
   logic signed [ACC_W-1:0]        d1_ext;
   logic signed [ACC_W-1:0]        d2_ext;
   logic        [RND_W-1:0]        rnd;
   logic signed [SHR_W-1:0]        shr;
   logic signed [SAMPLE_WIDTH-1:0] y_clip;
   logic                           y_hit;
   logic signed [STATE_WIDTH-1:0]  d_clip;
   logic                           d_hit;

   // Operand selection for the shared multiplier.
   always_comb begin
      samp_op = (ctrl.samp_sel == bqf_pkg::SAMP_Y) ? y_ff : x_ff;
      case (ctrl.coef_sel)
         bqf_pkg::COEF_B0: coef_op = coefs[bqf_pkg::CSR_B0];
         bqf_pkg::COEF_B1: coef_op = coefs[bqf_pkg::CSR_B1];
         bqf_pkg::COEF_B2: coef_op = coefs[bqf_pkg::CSR_B2];
         bqf_pkg::COEF_A1: coef_op = coefs[bqf_pkg::CSR_A1];
         bqf_pkg::COEF_A2: coef_op = coefs[bqf_pkg::CSR_A2];
         default:          coef_op = coefs[bqf_pkg::CSR_B0];
      endcase
      prod_in = samp_op * coef_op;
   end

   // Sign extension of the product and the delay terms to accumulator width.
   assign prod_ext = {{(ACC_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign d1_ext   = {{(ACC_W - STATE_WIDTH){d1_ff[STATE_WIDTH-1]}}, d1_ff};
   assign d2_ext   = {{(ACC_W - STATE_WIDTH){d2_ff[STATE_WIDTH-1]}}, d2_ff};

   // Accumulator step.
   always_comb begin
      case (ctrl.acc_op)
         bqf_pkg::ACC_ADD_D1: acc_in = d1_ext + prod_ext;
         bqf_pkg::ACC_ADD_D2: acc_in = d2_ext + prod_ext;
         bqf_pkg::ACC_SUB:    acc_in = acc_ff - prod_ext;
         bqf_pkg::ACC_LOAD:   acc_in = prod_ext;
         default:             acc_in = acc_ff;
      endcase
   end

   // Round half up to the sample format and clip to the sample range.
   always_comb begin
      rnd = {acc_ff[ACC_W-1], acc_ff} + ROUND_BIAS;
      shr = rnd[RND_W-1:FRAC];
      if (shr > $signed(Y_MAX)) begin
         y_clip = Y_MAX[SAMPLE_WIDTH-1:0];
         y_hit  = 1'b1;
      end else if (shr < $signed(Y_MIN)) begin
         y_clip = Y_MIN[SAMPLE_WIDTH-1:0];
         y_hit  = 1'b1;
      end else begin
         y_clip = shr[SAMPLE_WIDTH-1:0];
         y_hit  = 1'b0;
      end
   end

   // Clip the accumulator to the delay term range.
   always_comb begin
      if (acc_ff > $signed(D_MAX)) begin
         d_clip = D_MAX[STATE_WIDTH-1:0];
         d_hit  = 1'b1;
      end else if (acc_ff < $signed(D_MIN)) begin
         d_clip = D_MIN[STATE_WIDTH-1:0];
         d_hit  = 1'b1;
      end else begin
         d_clip = acc_ff[STATE_WIDTH-1:0];
         d_hit  = 1'b0;
      end
   end

   // Next values of the sample, output and delay registers.
   always_comb begin
      x_in   = ctrl.load_x ? sample_in : x_ff;
      y_in   = ctrl.load_y ? y_clip : y_ff;
      d1_in  = ctrl.load_d1 ? d_clip : d1_ff;
      d2_in  = ctrl.load_d2 ? d_clip : d2_ff;
      sat_in = sat_ff;
      if (ctrl.load_x) begin
         sat_in = 1'b0;
      end else if ((ctrl.load_y && y_hit) || ((ctrl.load_d1 || ctrl.load_d2) && d_hit)) begin
         sat_in = 1'b1;
      end
   end

   // Datapath registers; only the delay terms are state that reset clears.
   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      sat_ff  <= sat_in;
      if (reset) begin
         d1_ff <= '0;
         d2_ff <= '0;
      end else begin
         d1_ff <= d1_in;
         d2_ff <= d2_in;
      end
   end

   assign sample_out = y_ff;
   assign saturated  = sat_ff;

endmodule

@@ design/bqf_seq.sv @@
// Step sequencer of the biquad filter.
// Walks the shared multiply-accumulate unit through one item and drives its control word.
// Depends on bqf_pkg.
module bqf_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              out_free,
   output logic              req_ready,
   output bqf_pkg::ctrl_type ctrl
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MB0,
      ST_AY,
      ST_RY,
      ST_MA1,
      ST_MB2,
      ST_CD1,
      ST_SA2,
      ST_CD2,
      ST_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   // A new item is taken when idle, or when the last one is handed to the output register.
   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_FIN) && out_free);
   assign accept    = req_valid && req_ready;

   // Control word and next state for each step.
   always_comb begin
      ctrl          = '0;
      ctrl.samp_sel = bqf_pkg::SAMP_X;
      ctrl.coef_sel = bqf_pkg::COEF_B0;
      ctrl.acc_op   = bqf_pkg::ACC_HOLD;
      ctrl.load_x   = accept;
      state_in      = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_MB0;
         end
         ST_MB0: begin
            state_in = ST_AY;
         end
         ST_AY: begin
            ctrl.acc_op   = bqf_pkg::ACC_ADD_D1;
            ctrl.coef_sel = bqf_pkg::COEF_B1;
            state_in      = ST_RY;
         end
         ST_RY: begin
            ctrl.load_y = 1'b1;
            ctrl.acc_op = bqf_pkg::ACC_ADD_D2;
            state_in    = ST_MA1;
         end
         ST_MA1: begin
            ctrl.samp_sel = bqf_pkg::SAMP_Y;
            ctrl.coef_sel = bqf_pkg::COEF_A1;
            state_in      = ST_MB2;
         end
         ST_MB2: begin
            ctrl.acc_op   = bqf_pkg::ACC_SUB;
            ctrl.coef_sel = bqf_pkg::COEF_B2;
            state_in      = ST_CD1;
         end
         ST_CD1: begin
            ctrl.load_d1  = 1'b1;
            ctrl.acc_op   = bqf_pkg::ACC_LOAD;
            ctrl.samp_sel = bqf_pkg::SAMP_Y;
            ctrl.coef_sel = bqf_pkg::COEF_A2;
            state_in      = ST_SA2;
         end
         ST_SA2: begin
            ctrl.acc_op = bqf_pkg::ACC_SUB;
            state_in    = ST_CD2;
         end
         ST_CD2: begin
            ctrl.load_d2 = 1'b1;
            state_in     = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               ctrl.load_out = 1'b1;
               state_in      = accept ? ST_MB0 : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/biquad_iir_filter.sv @@
// Biquad IIR filter, one second-order section in transposed direct form II.
// Each item runs through the nine sequencer steps of the single shared multiplier and
// accumulator; the next is taken in the last step, once the output register is free.
// Reset (synchronous) clears the delay terms, loads b0 = 1.0 and the other coefficients 0,
// and empties the output register.
module biquad_iir_filter #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int COEF_WIDTH   = 32,
   parameter int STATE_WIDTH  = 48
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [SAMPLE_WIDTH-1:0]             req_sample_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [SAMPLE_WIDTH-1:0]             rsp_sample_out,
   output logic                                rsp_saturated,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bqf_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COEF_WIDTH-1:0]               csr_data
);

   localparam logic [COEF_WIDTH-1:0] B0_RESET = COEF_WIDTH'(1) << (COEF_WIDTH - 4);
   localparam logic [bqf_pkg::NUM_COEFS-1:0][COEF_WIDTH-1:0] COEFS_RESET =
      {{((bqf_pkg::NUM_COEFS - 1) * COEF_WIDTH){1'b0}}, B0_RESET};

   logic [bqf_pkg::NUM_COEFS-1:0][COEF_WIDTH-1:0] coefs_ff, coefs_in;
   logic                                          rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_WIDTH-1:0]                       rsp_sample_ff, rsp_sample_in;
   logic                                          rsp_sat_ff, rsp_sat_in;
   bqf_pkg::ctrl_type                             ctrl;
   logic                                          out_free;
   logic [SAMPLE_WIDTH-1:0]                       mac_sample;
   logic                                          mac_sat;

   // Coefficient registers; writes to an unknown index are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      coefs_in = coefs_ff;
      if (csr_valid) begin
         case (csr_index)
            bqf_pkg::CSR_B0: coefs_in[bqf_pkg::CSR_B0] = csr_data;
            bqf_pkg::CSR_B1: coefs_in[bqf_pkg::CSR_B1] = csr_data;
            bqf_pkg::CSR_B2: coefs_in[bqf_pkg::CSR_B2] = csr_data;
            bqf_pkg::CSR_A1: coefs_in[bqf_pkg::CSR_A1] = csr_data;
            bqf_pkg::CSR_A2: coefs_in[bqf_pkg::CSR_A2] = csr_data;
            default:         coefs_in = coefs_ff;
         endcase
      end
   end

   // Output register: filled at the end of an item, emptied when the item is taken.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in  = ctrl.load_out || (rsp_valid_ff && !rsp_ready);
      rsp_sample_in = ctrl.load_out ? mac_sample : rsp_sample_ff;
      rsp_sat_in    = ctrl.load_out ? mac_sat : rsp_sat_ff;
   end

   always_ff @(posedge clock) begin
      rsp_sample_ff <= rsp_sample_in;
      rsp_sat_ff    <= rsp_sat_in;
      if (reset) begin
         coefs_ff     <= COEFS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         coefs_ff     <= coefs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Step sequencer.
   bqf_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .req_ready (req_ready),
      .ctrl      (ctrl)
   );

   // Shared multiply-accumulate unit with the delay terms.
   bqf_mac #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COEF_WIDTH   (COEF_WIDTH),
      .STATE_WIDTH  (STATE_WIDTH)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .sample_in  (req_sample_in),
      .coefs      (coefs_ff),
      .sample_out (mac_sample),
      .saturated  (mac_sat)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_saturated  = rsp_sat_ff;

endmodule
